@@ rtl/mgs_pkg.sv @@
package mgs_pkg;

   // Frame size and fixed-point format.
   localparam int MAX_PIXELS_LOG2 = 22;
   localparam int FRAC_BITS       = 16;

   // Widths that follow from the frame size and the format.
   localparam int NW   = MAX_PIXELS_LOG2 + 1;      // pixel count
   localparam int SW   = MAX_PIXELS_LOG2 + 8;      // sum of values
   localparam int QW   = MAX_PIXELS_LOG2 + 16;     // sum of squares or products
   localparam int BW   = 2 * MAX_PIXELS_LOG2 + 32; // SSIM factors A, B, D1, D2
   localparam int PW   = 2 * BW;                   // product of two factors
   localparam int QTW  = FRAC_BITS + 2;            // quotient bits
   localparam int RW   = PW + FRAC_BITS;           // division remainder
   localparam int DW   = RW + 2;                   // shifted divisor
   localparam int SSW  = FRAC_BITS + 1;            // SSIM value
   localparam int SUMW = FRAC_BITS + 3;            // sum of three channel values
   localparam int CNTW = $clog2(QTW + 1);

   // Division by three as a multiply by a reciprocal and a shift.
   localparam int RECIP_SH = FRAC_BITS + 3;
   localparam int RECIPW   = FRAC_BITS + 2;
   localparam logic [RECIPW-1:0] RECIP = RECIPW'(((1 << RECIP_SH) + 2) / 3);

   // SSIM constants scaled by 10000.
   localparam logic [BW-1:0] C1_X10K   = BW'(65025);
   localparam logic [BW-1:0] C2_X10K   = BW'(585225);
   localparam logic [BW-1:0] SCALE_ONE = BW'(10000);
   localparam logic [BW-1:0] SCALE_TWO = BW'(20000);

   localparam logic [SSW-1:0] ONE     = SSW'(1) << FRAC_BITS;
   localparam logic [NW-1:0]  PIX_MAX = NW'(1) << MAX_PIXELS_LOG2;

   // Configuration register map.
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 17;
   localparam logic [CSR_IW-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_THRESH = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MIN    = 2'd2;

   localparam logic [SSW-1:0] THRESH_RESET = 17'd62259;
   localparam logic [9:0]     MIN_RESET    = 10'd10;

endpackage

@@ rtl/masked_global_ssim_unit.sv @@
// Masked global SSIM unit. Pixels with a skin byte other than 255 are accumulated, up to
// PIX_MAX per frame, at one transaction per cycle while req_stall is low. The transaction
// flagged last_pixel then holds req_stall high while the end-of-frame SSIM is computed by
// a single bit-serial shift-and-add multiplier and an 18-step restoring divider; each
// multiply shifts through its multiplier operand one bit at a time. A too-small region
// skips this and goes straight to the result register. The result register lets the next
// frame start accumulating while the previous result still waits on rsp_stall.
module masked_global_ssim_unit
   import mgs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_orig_c0,
   input  logic [7:0]        req_orig_c1,
   input  logic [7:0]        req_orig_c2,
   input  logic [7:0]        req_proc_c0,
   input  logic [7:0]        req_proc_c1,
   input  logic [7:0]        req_proc_c2,
   input  logic [7:0]        req_skin_level,
   input  logic              req_last_pixel,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SSW-1:0]    rsp_ssim_q16,
   output logic              rsp_passes,
   output logic              rsp_region_too_small,
   output logic [NW-1:0]     rsp_region_pixels,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_ACC, ST_FIN, ST_LOAD, ST_MUL, ST_DIV, ST_NEXT, ST_AVG, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NN, OP_C1, OP_C2, OP_XY, OP_A, OP_NXY, OP_B, OP_XX, OP_YY,
      OP_D1, OP_NSQ, OP_D2, OP_DEN, OP_NUM
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [SW-1:0] sum_orig_ff [3];
   logic [SW-1:0] sum_orig_in [3];
   logic [SW-1:0] sum_proc_ff [3];
   logic [SW-1:0] sum_proc_in [3];
   logic [QW-1:0] sum_orig_sq_ff [3];
   logic [QW-1:0] sum_orig_sq_in [3];
   logic [QW-1:0] sum_proc_sq_ff [3];
   logic [QW-1:0] sum_proc_sq_in [3];
   logic [QW-1:0] sum_cross_ff [3];
   logic [QW-1:0] sum_cross_in [3];
   logic [NW-1:0] counted_ff, counted_in;

   logic           mode_ff, mode_in;
   logic [SSW-1:0] thresh_ff, thresh_in;
   logic [9:0]     min_ff, min_in;

   logic [1:0]      ch_ff, ch_in;
   logic [PW-1:0]   mx_ff, mx_in;
   logic [BW-1:0]   my_ff, my_in;
   logic [PW-1:0]   acc_ff, acc_in;
   logic [BW-1:0]   nn_ff, nn_in;
   logic [BW-1:0]   c1nn_ff, c1nn_in;
   logic [BW-1:0]   c2nn_ff, c2nn_in;
   logic [BW-1:0]   tmp_ff, tmp_in;
   logic [BW-1:0]   q_ff, q_in;
   logic [BW-1:0]   a_ff, a_in;
   logic [BW-1:0]   b_ff, b_in;
   logic [BW-1:0]   d1_ff, d1_in;
   logic [BW-1:0]   d2_ff, d2_in;
   logic [PW-1:0]   den_ff, den_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   dsr_ff, dsr_in;
   logic [QTW-1:0]  qt_ff, qt_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [SUMW-1:0] ssum_ff, ssum_in;
   logic [SSW-1:0]  ssim_ff, ssim_in;
   logic            small_ff, small_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [SSW-1:0] rsp_ssim_ff, rsp_ssim_in;
   logic           rsp_passes_ff, rsp_passes_in;
   logic           rsp_small_ff, rsp_small_in;
   logic [NW-1:0]  rsp_pixels_ff, rsp_pixels_in;

   logic [7:0]             ox [3];
   logic [7:0]             py [3];
   logic                   accept;
   logic                   counts;
   logic [BW-1:0]          prod;
   logic [BW-1:0]          psum;
   logic                   div_ge;
   logic [QTW-1:0]         qt_nxt;
   logic [SSW-1:0]         chan;
   logic [SUMW+RECIPW-1:0] avg_prod;

   assign req_stall            = (state_ff != ST_ACC);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ssim_q16         = rsp_ssim_ff;
   assign rsp_passes           = rsp_passes_ff;
   assign rsp_region_too_small = rsp_small_ff;
   assign rsp_region_pixels    = rsp_pixels_ff;

   // Shared datapath terms.
   assign accept   = req_valid && !req_stall;
   assign counts   = (req_skin_level != 8'hFF) && (counted_ff < PIX_MAX);
   assign prod     = acc_ff[BW-1:0];
   assign div_ge   = ({2'b00, rem_ff} >= dsr_ff);
   assign qt_nxt   = {qt_ff[QTW-2:0], div_ge};
   assign chan     = (qt_nxt > QTW'(ONE)) ? ONE : qt_nxt[SSW-1:0];
   assign avg_prod = SUMW'(ssum_ff) * RECIP;

   always_comb begin
      ox[0] = req_orig_c0;
      ox[1] = req_orig_c1;
      ox[2] = req_orig_c2;
      py[0] = req_proc_c0;
      py[1] = req_proc_c1;
      py[2] = req_proc_c2;
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      sum_orig_in    = sum_orig_ff;
      sum_proc_in    = sum_proc_ff;
      sum_orig_sq_in = sum_orig_sq_ff;
      sum_proc_sq_in = sum_proc_sq_ff;
      sum_cross_in   = sum_cross_ff;
      counted_in     = counted_ff;
      mode_in        = mode_ff;
      thresh_in      = thresh_ff;
      min_in         = min_ff;
      ch_in          = ch_ff;
      mx_in          = mx_ff;
      my_in          = my_ff;
      acc_in         = acc_ff;
      nn_in          = nn_ff;
      c1nn_in        = c1nn_ff;
      c2nn_in        = c2nn_ff;
      tmp_in         = tmp_ff;
      q_in           = q_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      d1_in          = d1_ff;
      d2_in          = d2_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      dsr_in         = dsr_ff;
      qt_in          = qt_ff;
      cnt_in         = cnt_ff;
      ssum_in        = ssum_ff;
      ssim_in        = ssim_ff;
      small_in       = small_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ssim_in    = rsp_ssim_ff;
      rsp_passes_in  = rsp_passes_ff;
      rsp_small_in   = rsp_small_ff;
      rsp_pixels_in  = rsp_pixels_ff;
      psum           = '0;

      // Configuration writes.
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:   mode_in   = csr_wdata[0];
            CSR_THRESH: thresh_in = csr_wdata[SSW-1:0];
            CSR_MIN:    min_in    = csr_wdata[9:0];
            default:    ;
         endcase
      end

      // The result register empties when the consumer takes the transaction.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_ACC: begin
            if (accept) begin
               if (counts) begin
                  for (int c = 0; c < 3; c++) begin
                     sum_orig_in[c]    = sum_orig_ff[c] + SW'(ox[c]);
                     sum_proc_in[c]    = sum_proc_ff[c] + SW'(py[c]);
                     sum_orig_sq_in[c] = sum_orig_sq_ff[c]
                                       + QW'({8'd0, ox[c]} * {8'd0, ox[c]});
                     sum_proc_sq_in[c] = sum_proc_sq_ff[c]
                                       + QW'({8'd0, py[c]} * {8'd0, py[c]});
                     sum_cross_in[c]   = sum_cross_ff[c]
                                       + QW'({8'd0, ox[c]} * {8'd0, py[c]});
                  end
                  counted_in = counted_ff + NW'(1);
               end
               if (req_last_pixel) begin
                  state_in = ST_FIN;
               end
            end
         end

         ST_FIN: begin
            small_in = (counted_ff == '0) || (counted_ff < NW'(min_ff));
            ch_in    = 2'd0;
            ssum_in  = '0;
            op_in    = OP_NN;
            if ((counted_ff == '0) || (counted_ff < NW'(min_ff))) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_LOAD;
            end
         end

         // Operand selection for the shared multiplier.
         ST_LOAD: begin
            acc_in   = '0;
            state_in = ST_MUL;
            case (op_ff)
               OP_NN: begin
                  mx_in = PW'(counted_ff);
                  my_in = BW'(counted_ff);
               end
               OP_C1: begin
                  mx_in = PW'(nn_ff);
                  my_in = C1_X10K;
               end
               OP_C2: begin
                  mx_in = PW'(nn_ff);
                  my_in = C2_X10K;
               end
               OP_XY: begin
                  mx_in = PW'(sum_orig_ff[ch_ff]);
                  my_in = BW'(sum_proc_ff[ch_ff]);
               end
               OP_A, OP_B: begin
                  mx_in = PW'(tmp_ff);
                  my_in = SCALE_TWO;
               end
               OP_NXY: begin
                  mx_in = PW'(sum_cross_ff[ch_ff]);
                  my_in = BW'(counted_ff);
               end
               OP_XX: begin
                  mx_in = PW'(sum_orig_ff[ch_ff]);
                  my_in = BW'(sum_orig_ff[ch_ff]);
               end
               OP_YY: begin
                  mx_in = PW'(sum_proc_ff[ch_ff]);
                  my_in = BW'(sum_proc_ff[ch_ff]);
               end
               OP_D1, OP_D2: begin
                  mx_in = PW'(tmp_ff);
                  my_in = SCALE_ONE;
               end
               OP_NSQ: begin
                  mx_in = PW'(sum_orig_sq_ff[ch_ff]) + PW'(sum_proc_sq_ff[ch_ff]);
                  my_in = BW'(counted_ff);
               end
               OP_DEN: begin
                  mx_in = PW'(d1_ff);
                  my_in = d2_ff;
               end
               OP_NUM: begin
                  mx_in = PW'(a_ff);
                  my_in = b_ff;
               end
               default: begin
                  mx_in = '0;
                  my_in = '0;
               end
            endcase
         end

         // Shift-and-add multiply, then store the product where the step needs it.
         ST_MUL: begin
            if (my_ff != '0) begin
               if (my_ff[0]) begin
                  acc_in = acc_ff + mx_ff;
               end
               mx_in = mx_ff << 1;
               my_in = my_ff >> 1;
            end else begin
               state_in = ST_LOAD;
               case (op_ff)
                  OP_NN: begin
                     nn_in = prod;
                     op_in = OP_C1;
                  end
                  OP_C1: begin
                     c1nn_in = prod;
                     op_in   = OP_C2;
                  end
                  OP_C2: begin
                     c2nn_in = prod;
                     op_in   = OP_XY;
                  end
                  OP_XY: begin
                     tmp_in = prod;
                     op_in  = OP_A;
                  end
                  OP_A: begin
                     q_in  = prod;
                     a_in  = prod + c1nn_ff;
                     op_in = OP_NXY;
                  end
                  OP_NXY: begin
                     tmp_in = prod;
                     op_in  = OP_B;
                  end
                  OP_B: begin
                     // A covariance factor that is not positive gives a channel SSIM of zero.
                     psum = prod + c2nn_ff;
                     if (psum <= q_ff) begin
                        state_in = ST_NEXT;
                     end else begin
                        b_in  = psum - q_ff;
                        op_in = OP_XX;
                     end
                  end
                  OP_XX: begin
                     tmp_in = prod;
                     op_in  = OP_YY;
                  end
                  OP_YY: begin
                     tmp_in = tmp_ff + prod;
                     op_in  = OP_D1;
                  end
                  OP_D1: begin
                     q_in  = prod;
                     d1_in = prod + c1nn_ff;
                     op_in = OP_NSQ;
                  end
                  OP_NSQ: begin
                     tmp_in = prod;
                     op_in  = OP_D2;
                  end
                  OP_D2: begin
                     // The variance factor saturates at zero.
                     psum  = prod + c2nn_ff;
                     d2_in = (psum >= q_ff) ? (psum - q_ff) : '0;
                     op_in = OP_DEN;
                  end
                  OP_DEN: begin
                     // A zero denominator reads as a perfect match.
                     den_in = acc_ff;
                     if (acc_ff == '0) begin
                        ssum_in  = ssum_ff + SUMW'(ONE);
                        state_in = ST_NEXT;
                     end else begin
                        op_in = OP_NUM;
                     end
                  end
                  OP_NUM: begin
                     rem_in   = {acc_ff, {FRAC_BITS{1'b0}}};
                     dsr_in   = DW'({den_ff, {(QTW-1){1'b0}}});
                     qt_in    = '0;
                     cnt_in   = '0;
                     state_in = ST_DIV;
                  end
                  default: state_in = ST_NEXT;
               endcase
            end
         end

         // Restoring division, one quotient bit per cycle.
         ST_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dsr_ff[RW-1:0];
            end
            dsr_in = dsr_ff >> 1;
            qt_in  = qt_nxt;
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(QTW - 1)) begin
               ssum_in  = ssum_ff + SUMW'(chan);
               state_in = ST_NEXT;
            end
         end

         ST_NEXT: begin
            if (!mode_ff || (ch_ff == 2'd2)) begin
               state_in = ST_AVG;
            end else begin
               ch_in    = ch_ff + 2'd1;
               op_in    = OP_XY;
               state_in = ST_LOAD;
            end
         end

         // In three-channel mode, average by a reciprocal multiply; else pass one channel through.
         ST_AVG: begin
            if (mode_ff) begin
               ssim_in = SSW'(avg_prod >> RECIP_SH);
            end else begin
               ssim_in = ssum_ff[SSW-1:0];
            end
            state_in = ST_OUT;
         end

         // Hand the result over and clear the frame sums.
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_ssim_in   = small_ff ? ONE : ssim_ff;
               rsp_passes_in = small_ff ? 1'b1 : (ssim_ff > thresh_ff);
               rsp_small_in  = small_ff;
               rsp_pixels_in = counted_ff;
               for (int c = 0; c < 3; c++) begin
                  sum_orig_in[c]    = '0;
                  sum_proc_in[c]    = '0;
                  sum_orig_sq_in[c] = '0;
                  sum_proc_sq_in[c] = '0;
                  sum_cross_in[c]   = '0;
               end
               counted_in = '0;
               state_in   = ST_ACC;
            end
         end

         default: state_in = ST_ACC;
      endcase
   end

   // State, control and accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         op_ff        <= OP_NN;
         counted_ff   <= '0;
         mode_ff      <= 1'b1;
         thresh_ff    <= THRESH_RESET;
         min_ff       <= MIN_RESET;
         ch_ff        <= '0;
         cnt_ff       <= '0;
         small_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            sum_orig_ff[c]    <= '0;
            sum_proc_ff[c]    <= '0;
            sum_orig_sq_ff[c] <= '0;
            sum_proc_sq_ff[c] <= '0;
            sum_cross_ff[c]   <= '0;
         end
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         counted_ff     <= counted_in;
         mode_ff        <= mode_in;
         thresh_ff      <= thresh_in;
         min_ff         <= min_in;
         ch_ff          <= ch_in;
         cnt_ff         <= cnt_in;
         small_ff       <= small_in;
         rsp_valid_ff   <= rsp_valid_in;
         sum_orig_ff    <= sum_orig_in;
         sum_proc_ff    <= sum_proc_in;
         sum_orig_sq_ff <= sum_orig_sq_in;
         sum_proc_sq_ff <= sum_proc_sq_in;
         sum_cross_ff   <= sum_cross_in;
      end
   end

   // Datapath and result payload registers.
   always_ff @(posedge clock) begin
      mx_ff         <= mx_in;
      my_ff         <= my_in;
      acc_ff        <= acc_in;
      nn_ff         <= nn_in;
      c1nn_ff       <= c1nn_in;
      c2nn_ff       <= c2nn_in;
      tmp_ff        <= tmp_in;
      q_ff          <= q_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      d1_ff         <= d1_in;
      d2_ff         <= d2_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      qt_ff         <= qt_in;
      ssum_ff       <= ssum_in;
      ssim_ff       <= ssim_in;
      rsp_ssim_ff   <= rsp_ssim_in;
      rsp_passes_ff <= rsp_passes_in;
      rsp_small_ff  <= rsp_small_in;
      rsp_pixels_ff <= rsp_pixels_in;
   end

endmodule

@@ verif/masked_global_ssim_unit_test.sv @@
`timescale 1ns / 1ps

module masked_global_ssim_unit_test;
   import mgs_pkg::*;

   localparam logic [CSR_IW-1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD = 2500;

   typedef struct {
      logic [7:0] orig [3];
      logic [7:0] proc [3];
      logic [7:0] skin;
      logic       last;
      logic       drain_first;
   } pixel_type;

   typedef struct {
      logic [SSW-1:0] ssim;
      logic           passes;
      logic           too_small;
      logic [NW-1:0]  pixels;
   } frame_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_orig_c0 = 0, req_orig_c1 = 0, req_orig_c2 = 0;
   logic [7:0] req_proc_c0 = 0, req_proc_c1 = 0, req_proc_c2 = 0;
   logic [7:0] req_skin_level = 0;
   logic req_last_pixel = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [SSW-1:0] rsp_ssim_q16;
   logic rsp_passes;
   logic rsp_region_too_small;
   logic [NW-1:0] rsp_region_pixels;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IW-1:0] csr_index = 0;
   logic [CSR_DW-1:0] csr_wdata = 0;

   masked_global_ssim_unit DUT (.*);

   always #5 clock = ~clock;

   // Pixel stream, frame results still owed, and the predictor's state.
   pixel_type pending_pixels[$];
   frame_result_type expected_frames[$];
   pixel_type cur_pixel;
   longint unsigned sum_x [3], sum_y [3], sum_xx [3], sum_yy [3], sum_xy [3];
   longint unsigned pixel_count = 0;
   logic mode_q = 1;
   logic [16:0] thresh_q = THRESH_RESET;
   logic [9:0] min_q = MIN_RESET;

   int mismatches = 0;
   bit no_idle = 0;
   bit hold_request = 0;
   int send_gap = 0;
   int recv_wait = 0;
   int quiet_cycles = 0;

   // Exact global SSIM of one channel in Q1.16, from the frame sums.
   function automatic logic [SSW-1:0] channel_ssim(int c, longint unsigned n);
      logic [255:0] sx, sy, sxsy, nn, t, a, p, q, b, d1, d2, num, den;
      logic [17:0] res, trial;
      sx = sum_x[c];
      sy = sum_y[c];
      sxsy = sx * sy;
      nn = 256'(n * n);
      a = sxsy * 20000 + nn * 65025;
      t = sum_xy[c];
      p = t * n * 20000 + nn * 585225;
      q = sxsy * 20000;
      if (p <= q)
         return '0;
      b = p - q;
      q = (sx * sx + sy * sy) * 10000;
      d1 = q + nn * 65025;
      t = sum_xx[c] + sum_yy[c];
      t = t * n * 10000 + nn * 585225;
      d2 = (t < q) ? '0 : t - q;
      den = d1 * d2;
      if (den == 0)
         return ONE;
      num = a * b * 65536;
      res = '0;
      for (int bit_i = FRAC_BITS + 1; bit_i >= 0; bit_i--) begin
         trial = res | (18'd1 << bit_i);
         if (den * trial <= num)
            res = trial;
      end
      return (res > ONE) ? ONE : res[SSW-1:0];
   endfunction

   // Accumulate one accepted pixel; a last pixel closes the frame.
   function automatic void accumulate_pixel(pixel_type px);
      frame_result_type r;
      logic [31:0] total;
      if (px.skin != 8'hFF && pixel_count < (64'd1 << MAX_PIXELS_LOG2)) begin
         for (int c = 0; c < 3; c++) begin
            sum_x[c] += px.orig[c];
            sum_y[c] += px.proc[c];
            sum_xx[c] += px.orig[c] * px.orig[c];
            sum_yy[c] += px.proc[c] * px.proc[c];
            sum_xy[c] += px.orig[c] * px.proc[c];
         end
         pixel_count++;
      end
      if (!px.last)
         return;
      if (pixel_count == 0 || pixel_count < min_q) begin
         r.ssim = ONE;
         r.passes = 1;
         r.too_small = 1;
      end else begin
         if (mode_q) begin
            total = channel_ssim(0, pixel_count) + channel_ssim(1, pixel_count)
                  + channel_ssim(2, pixel_count);
            r.ssim = SSW'(total / 3);
         end else begin
            r.ssim = channel_ssim(0, pixel_count);
         end
         r.passes = r.ssim > thresh_q;
         r.too_small = 0;
      end
      r.pixels = NW'(pixel_count);
      expected_frames.insert(expected_frames.size(), r);
      for (int c = 0; c < 3; c++) begin
         sum_x[c] = 0; sum_y[c] = 0; sum_xx[c] = 0; sum_yy[c] = 0; sum_xy[c] = 0;
      end
      pixel_count = 0;
   endfunction

   function automatic bit can_offer();
      if (pending_pixels.size() == 0)
         return 0;
      return !(pending_pixels[0].drain_first && expected_frames.size() > 0);
   endfunction

   task automatic offer_pixel();
      cur_pixel = pending_pixels[0];
      pending_pixels.delete(0);
      req_valid <= 1;
      req_orig_c0 <= cur_pixel.orig[0];
      req_orig_c1 <= cur_pixel.orig[1];
      req_orig_c2 <= cur_pixel.orig[2];
      req_proc_c0 <= cur_pixel.proc[0];
      req_proc_c1 <= cur_pixel.proc[1];
      req_proc_c2 <= cur_pixel.proc[2];
      req_skin_level <= cur_pixel.skin;
      req_last_pixel <= cur_pixel.last;
   endtask

   // Driver: predicts on each accepted transaction, then waits a random gap.
   always @(posedge clock) begin
      int g;
      if (reset) begin
         req_valid <= 0;
         send_gap <= 0;
      end else if (req_valid && !req_stall) begin
         accumulate_pixel(cur_pixel);
         g = no_idle ? 0 : $urandom_range(0, 8);
         if (g == 0 && can_offer()) begin
            offer_pixel();
         end else begin
            req_valid <= 0;
            send_gap <= g;
         end
      end else if (!req_valid) begin
         if (send_gap > 0)
            send_gap <= send_gap - 1;
         else if (can_offer())
            offer_pixel();
      end
   end

   // Monitor: checks each accepted result and draws the next stall.
   always @(posedge clock) begin
      frame_result_type e;
      int w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: ssim %0d pixels %0d",
                           rsp_ssim_q16, rsp_region_pixels);
            end else begin
               e = expected_frames[0];
               expected_frames.delete(0);
               if (rsp_ssim_q16 !== e.ssim || rsp_passes !== e.passes ||
                   rsp_region_too_small !== e.too_small ||
                   rsp_region_pixels !== e.pixels) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Result mismatch: expected ssim %0d pass %0d small %0d pix %0d",
                              e.ssim, e.passes, e.too_small, e.pixels,
                              ", got ssim %0d pass %0d small %0d pix %0d",
                              rsp_ssim_q16, rsp_passes, rsp_region_too_small,
                              rsp_region_pixels);
               end
            end
         end
         if (hold_request) begin
            hold_request = 0;
            recv_wait <= LONG_HOLD;
            rsp_stall <= 1;
         end else if (rsp_valid && !rsp_stall) begin
            w = no_idle ? 0 : $urandom_range(0, 8);
            recv_wait <= w;
            rsp_stall <= (w != 0);
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_stall <= (recv_wait > 1);
         end
      end
   end

   // Watchdog on cycles in which no transaction of any channel completes.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic write_register(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_MODE) mode_q = value[0];
      else if (idx == CSR_THRESH) thresh_q = value[16:0];
      else if (idx == CSR_MIN) min_q = value[9:0];
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_valid || expected_frames.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Styles: 0 random, 1 processed close to original, 2 constant value,
   // 3 opposite values (negative covariance). mask_pct is the share of masked pixels.
   task automatic push_frame(int len, int style, int mask_pct, bit drain = 0,
                             logic [7:0] level = 0);
      pixel_type px;
      int noise;
      for (int i = 0; i < len; i++) begin
         noise = $urandom_range(0, 2) == 0 ? 40 : 6;
         for (int c = 0; c < 3; c++) begin
            case (style)
               0: begin
                  px.orig[c] = $urandom_range(0, 255);
                  px.proc[c] = $urandom_range(0, 255);
               end
               1: begin
                  px.orig[c] = $urandom_range(0, 255);
                  px.proc[c] = 8'(int'(px.orig[c]) + $urandom_range(0, noise) - noise / 2);
               end
               2: begin
                  px.orig[c] = level;
                  px.proc[c] = level;
               end
               default: begin
                  px.orig[c] = (i % 2) ? 8'd255 : 8'd0;
                  px.proc[c] = (i % 2) ? 8'd0 : 8'd255;
               end
            endcase
         end
         if ($urandom_range(1, 100) <= mask_pct)
            px.skin = 8'hFF;
         else
            px.skin = $urandom_range(0, 5) == 0 ? 8'hFE : 8'($urandom_range(0, 254));
         px.last = (i == len - 1);
         px.drain_first = drain && (i == 0);
         pending_pixels.insert(pending_pixels.size(), px);
      end
   endtask

   task automatic random_frames(int pixels);
      int len;
      while (pixels > 0) begin
         len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 8) : $urandom_range(8, 40);
         push_frame(len, $urandom_range(0, 3) == 0 ? 0 : 1,
                    $urandom_range(0, 4) == 0 ? 60 : 15, $urandom_range(0, 15) == 0);
         pixels -= len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;

      // Directed frames under the reset settings.
      push_frame(12, 2, 0, 0, 8'd0);
      push_frame(12, 2, 0, 0, 8'd255);
      push_frame(12, 3, 0);
      push_frame(5, 0, 100);
      push_frame(1, 0, 0);
      push_frame(10, 1, 0);
      push_frame(9, 1, 0);
      push_frame(20, 0, 0, 1);
      wait_idle();

      // Single channel, lowest threshold, no minimum; a bad index is ignored.
      write_register(CSR_MODE, 17'h1FFFE);
      write_register(CSR_THRESH, 17'd0);
      write_register(CSR_MIN, 17'h1FC00);
      write_register(CSR_UNUSED, 17'h1FFFF);
      push_frame(1, 0, 0);
      push_frame(3, 0, 100);
      random_frames(150);
      wait_idle();

      // Long receiver hold while pixels keep coming, then burst with no idling.
      hold_request = 1;
      random_frames(150);
      wait_idle();
      no_idle = 1;
      random_frames(100);
      wait_idle();
      no_idle = 0;

      // Three channels, threshold at one, largest minimum.
      write_register(CSR_MODE, 17'd1);
      write_register(CSR_THRESH, 17'd65536);
      write_register(CSR_MIN, 17'd1023);
      push_frame(100, 1, 5);
      random_frames(60);
      wait_idle();

      // A minimum that is just met and one that is just missed.
      write_register(CSR_MIN, 17'd25);
      push_frame(25, 1, 0);
      push_frame(24, 1, 0);
      wait_idle();

      // Thresholds around typical values.
      write_register(CSR_THRESH, 17'($urandom_range(55000, 65535)));
      write_register(CSR_MIN, 17'($urandom_range(1, 20)));
      random_frames(120);
      wait_idle();
      write_register(CSR_MODE, 17'd0);
      write_register(CSR_THRESH, 17'h1FFFF);
      random_frames(100);
      wait_idle();

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
